FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the decoder RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Types and constants of the preorder-tree Huffman decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

    // sizes
    localparam int SYMBOL_BITS  = 8;
    localparam int NODE_DEPTH   = 512;
    localparam int STACK_DEPTH  = 256;

    localparam int NODE_IDX_W   = $clog2(NODE_DEPTH);
    localparam int NODE_CNT_W   = $clog2(NODE_DEPTH + 1);
    localparam int STACK_ADDR_W = $clog2(STACK_DEPTH);
    localparam int STACK_LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int LINK_PAY_W   = (NODE_IDX_W > SYMBOL_BITS) ? NODE_IDX_W : SYMBOL_BITS;
    localparam int STATUS_W     = 3;

    // func codes
    localparam logic [1:0] FUNC_SHAPE = 2'd0;
    localparam logic [1:0] FUNC_MSG   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DECODED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHAPE_LATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_TREE   = 3'd4;

    // channel words
    typedef struct packed {
        logic [1:0]             func;
        logic                   bit_value;
        logic [SYMBOL_BITS-1:0] leaf_symbol;
    } t_in_word;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic [STATUS_W-1:0]    status;
    } t_out_word;

    // one child link: leaf flag plus child index or leaf symbol
    typedef struct packed {
        logic                  leaf;
        logic [LINK_PAY_W-1:0] pay;
    } t_link;

    // both links of a node, indexed by side
    typedef t_link [1:0] t_link_pair;

    typedef struct packed {
        logic                  en;
        logic [NODE_IDX_W-1:0] addr;
        logic                  lane;
        t_link                 data;
    } t_link_wr;

    typedef struct packed {
        logic                  en;
        logic [NODE_IDX_W-1:0] addr;
    } t_link_rd;

    // loader verdict on one shape word
    typedef struct packed {
        logic                err;
        logic [STATUS_W-1:0] status;
    } t_shape_res;

    // second pipeline stage contents
    typedef struct packed {
        logic                lookup;
        logic                bit_value;
        logic [STATUS_W-1:0] status;
    } t_s2;

endpackage

`default_nettype wire

FILE: sv/htd_link_mem.sv
// ----------------------------------------------------------------------------
// htd_link_mem
// Node link memory: one entry per node, two side lanes written separately,
// one read port with a registered output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htd_link_mem (
    input  wire                 i_clk,
    input  htd_pkg::t_link_wr   i_wr,
    input  htd_pkg::t_link_rd   i_rd,
    output htd_pkg::t_link_pair o_rdata
);

    htd_pkg::t_link_pair r_mem [0:htd_pkg::NODE_DEPTH-1];
    htd_pkg::t_link_pair r_rdata;

    // lane write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr][i_wr.lane] <= i_wr.data;
        end
    end

    // registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/htd_loader.sv
// ----------------------------------------------------------------------------
// htd_loader
// Preorder tree loader: node counter, open parent stack with a cached top
// entry, and link writes into the node memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htd_loader (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_shape_en,
    input  wire                                i_clear,
    input  wire                                i_bit,
    input  wire [htd_pkg::SYMBOL_BITS-1:0]     i_sym,
    output logic                               o_ready,
    output htd_pkg::t_shape_res                o_res,
    output htd_pkg::t_link_wr                  o_link_wr
);

    // entries below the top of stack hold only a parent; their side is always one
    logic [htd_pkg::NODE_IDX_W-1:0]   r_stack [0:htd_pkg::STACK_DEPTH-1];
    logic [htd_pkg::NODE_IDX_W-1:0]   r_stack_rdata;

    logic [htd_pkg::STACK_LVL_W-1:0]  r_level, n_level;
    logic [htd_pkg::NODE_CNT_W-1:0]   r_next_free, n_next_free;
    logic                             r_ready, n_ready;
    logic                             r_pop_pend, n_pop_pend;
    logic [htd_pkg::NODE_IDX_W-1:0]   r_top_parent, n_top_parent;
    logic                             r_top_side, n_top_side;

    logic [htd_pkg::NODE_IDX_W-1:0]   top_parent;
    logic [htd_pkg::NODE_IDX_W-1:0]   idx;
    logic [htd_pkg::STACK_LVL_W-1:0]  lvl_m1;
    logic [htd_pkg::STACK_LVL_W-1:0]  lvl_m2;
    logic                             stk_we;
    logic                             stk_re;
    htd_pkg::t_shape_res              res;
    htd_pkg::t_link_wr                link_wr;

    // shape decision and next state
    always_comb begin
        top_parent   = r_pop_pend ? r_stack_rdata : r_top_parent;
        idx          = r_next_free[htd_pkg::NODE_IDX_W-1:0];
        lvl_m1       = r_level - 1'b1;
        lvl_m2       = r_level - 2'd2;
        res          = '0;
        link_wr      = '0;
        stk_we       = 1'b0;
        stk_re       = 1'b0;
        n_level      = r_level;
        n_next_free  = r_next_free;
        n_ready      = r_ready;
        n_pop_pend   = 1'b0;
        n_top_parent = top_parent;
        n_top_side   = r_top_side;

        if (i_clear) begin
            n_level     = '0;
            n_next_free = '0;
            n_ready     = 1'b0;
        end else if (i_shape_en) begin
            if (r_ready) begin
                res = '{err: 1'b1, status: htd_pkg::ST_SHAPE_LATE};
            end else if (r_next_free == '0) begin
                if (!i_bit) begin
                    // a leaf cannot be the root
                    res = '{err: 1'b1, status: htd_pkg::ST_BAD_TREE};
                end else begin
                    n_top_parent = '0;
                    n_top_side   = 1'b0;
                    n_level      = htd_pkg::STACK_LVL_W'(1);
                    n_next_free  = htd_pkg::NODE_CNT_W'(1);
                end
            end else if (r_next_free >= htd_pkg::NODE_CNT_W'(htd_pkg::NODE_DEPTH)) begin
                res = '{err: 1'b1, status: htd_pkg::ST_TABLE_FULL};
            end else if (r_level == '0) begin
                res = '{err: 1'b1, status: htd_pkg::ST_BAD_TREE};
            end else if (i_bit && !r_top_side &&
                         r_level >= htd_pkg::STACK_LVL_W'(htd_pkg::STACK_DEPTH)) begin
                // push would overflow the stack
                res = '{err: 1'b1, status: htd_pkg::ST_BAD_TREE};
            end else begin
                // attach the new node under the top parent
                link_wr.en       = 1'b1;
                link_wr.addr     = top_parent;
                link_wr.lane     = r_top_side;
                link_wr.data.leaf = !i_bit;
                link_wr.data.pay = i_bit ? htd_pkg::LINK_PAY_W'(idx)
                                         : htd_pkg::LINK_PAY_W'(i_sym);
                n_next_free      = r_next_free + 1'b1;

                if (!r_top_side) begin
                    if (i_bit) begin
                        // old top goes to memory with its side flipped
                        stk_we       = 1'b1;
                        n_top_parent = idx;
                        n_top_side   = 1'b0;
                        n_level      = r_level + 1'b1;
                    end else begin
                        n_top_side = 1'b1;
                    end
                end else if (i_bit) begin
                    // pop and push in one step: replace the top
                    n_top_parent = idx;
                    n_top_side   = 1'b0;
                end else if (r_level == htd_pkg::STACK_LVL_W'(1)) begin
                    n_level = '0;
                    n_ready = 1'b1;
                end else begin
                    // pop; the new top comes out of memory next cycle
                    stk_re     = 1'b1;
                    n_pop_pend = 1'b1;
                    n_top_side = 1'b1;
                    n_level    = lvl_m1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_next_free <= '0;
            r_ready     <= 1'b0;
            r_pop_pend  <= 1'b0;
        end else begin
            r_level     <= n_level;
            r_next_free <= n_next_free;
            r_ready     <= n_ready;
            r_pop_pend  <= n_pop_pend;
        end
    end

    // cached top of stack
    always_ff @(posedge i_clk) begin
        r_top_parent <= n_top_parent;
        r_top_side   <= n_top_side;
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[lvl_m1[htd_pkg::STACK_ADDR_W-1:0]] <= top_parent;
        end
        if (stk_re) begin
            r_stack_rdata <= r_stack[lvl_m2[htd_pkg::STACK_ADDR_W-1:0]];
        end
    end

    assign o_ready   = r_ready;
    assign o_res     = res;
    assign o_link_wr = link_wr;

endmodule

`default_nettype wire

FILE: sv/huffman_tree_load_and_decode_core.sv
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_core
// Rebuilds a Huffman tree from preorder shape words and decodes message bits
//
//   channel | direction | word              | handshake
//   --------+-----------+-------------------+-----------------------
//   in      | input     | func, bit, symbol | i_in_valid / o_in_stall
//   out     | output    | symbol, status    | o_out_valid / i_out_stall
//
// One word is taken per cycle while o_in_stall is low, shape and message
// words alike; a result passes through the second-stage register and then
// the output register. The node memory read is forwarded straight into the
// next walk address, so consecutive message bits do not wait on each other.
// Reset is synchronous and active low; memories are not cleared.
// A stalled output holds one result and one more in the second stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module huffman_tree_load_and_decode_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  htd_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output htd_pkg::t_out_word   o_out_word
);

    logic                            in_accept;
    logic                            shape_en;
    logic                            clear_en;
    logic                            tree_ready;
    htd_pkg::t_shape_res             shape_res;
    htd_pkg::t_link_wr               link_wr;
    htd_pkg::t_link_rd               link_rd;
    htd_pkg::t_link_pair             link_rdata;
    htd_pkg::t_link                  sel_link;

    logic                            r_s2_valid, n_s2_valid;
    htd_pkg::t_s2                    r_s2, n_s2;
    logic                            s2_emit;
    logic                            s2_retire;
    logic [htd_pkg::NODE_IDX_W-1:0]  r_walk, n_walk;
    logic [htd_pkg::NODE_IDX_W-1:0]  walk_eff;
    logic                            r_out_valid, n_out_valid;
    htd_pkg::t_out_word              r_out, n_out;

    // second stage: pick the link chosen by the message bit
    always_comb begin
        sel_link  = link_rdata[r_s2.bit_value];
        s2_emit   = r_s2_valid && (!r_s2.lookup || sel_link.leaf);
        s2_retire = r_s2_valid && (!s2_emit || !r_out_valid || !i_out_stall);
        if (r_s2_valid && r_s2.lookup) begin
            walk_eff = sel_link.leaf ? '0 : sel_link.pay[htd_pkg::NODE_IDX_W-1:0];
        end else begin
            walk_eff = r_walk;
        end
    end

    assign o_in_stall = r_s2_valid && !s2_retire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign shape_en   = in_accept && (i_in_word.func == htd_pkg::FUNC_SHAPE);
    assign clear_en   = in_accept && (i_in_word.func == htd_pkg::FUNC_CLEAR);

    htd_loader u_loader (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shape_en (shape_en),
        .i_clear    (clear_en),
        .i_bit      (i_in_word.bit_value),
        .i_sym      (i_in_word.leaf_symbol),
        .o_ready    (tree_ready),
        .o_res      (shape_res),
        .o_link_wr  (link_wr)
    );

    htd_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_wr    (link_wr),
        .i_rd    (link_rd),
        .o_rdata (link_rdata)
    );

    // first stage: classify the accepted word and issue the node read
    always_comb begin
        link_rd      = '0;
        link_rd.addr = walk_eff;
        n_s2         = r_s2;
        n_s2_valid   = r_s2_valid && !s2_retire;
        if (in_accept) begin
            n_s2.lookup    = 1'b0;
            n_s2.bit_value = i_in_word.bit_value;
            n_s2.status    = shape_res.status;
            case (i_in_word.func)
                htd_pkg::FUNC_SHAPE: begin
                    n_s2_valid = shape_res.err;
                end
                htd_pkg::FUNC_MSG: begin
                    n_s2_valid = 1'b1;
                    if (tree_ready) begin
                        n_s2.lookup = 1'b1;
                        link_rd.en  = 1'b1;
                    end else begin
                        n_s2.status = htd_pkg::ST_NOT_READY;
                    end
                end
                default: begin
                    n_s2_valid = 1'b0;
                end
            endcase
        end
    end

    // walk pointer and output register
    always_comb begin
        if (clear_en) begin
            n_walk = '0;
        end else if (s2_retire) begin
            n_walk = walk_eff;
        end else begin
            n_walk = r_walk;
        end

        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (s2_emit && s2_retire) begin
            n_out_valid = 1'b1;
            if (r_s2.lookup) begin
                n_out.symbol = sel_link.pay[htd_pkg::SYMBOL_BITS-1:0];
                n_out.status = htd_pkg::ST_DECODED;
            end else begin
                n_out.symbol = '0;
                n_out.status = r_s2.status;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_walk      <= '0;
        end else begin
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
            r_walk      <= n_walk;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s2  <= n_s2;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    `ASSERT_IMPLIES(a_lookup_needs_tree, i_clk, i_rst_n, r_s2_valid && r_s2.lookup, tree_ready, "lookup without a complete tree")
    `ASSERT_NEXT(a_msg_goes_lookup, i_clk, i_rst_n, in_accept && (i_in_word.func == htd_pkg::FUNC_MSG) && tree_ready, r_s2_valid && r_s2.lookup, "message word lost its lookup")
    `ASSERT_IMPLIES(a_err_symbol_zero, i_clk, i_rst_n, o_out_valid && (o_out_word.status != htd_pkg::ST_DECODED), o_out_word.symbol == '0, "error word carries a symbol")

endmodule

`default_nettype wire
